// ----- hdl/ipv4v_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4v_pkg
// Shared types, constants and helpers of the IPv4/UDP frame validator.
// ----------------------------------------------------------------------------
package ipv4v_pkg;

    // frame layout (byte positions from start of the Ethernet frame)
    localparam logic [15:0] MAC_END    = 16'd6;
    localparam logic [15:0] HDR_START  = 16'd14;
    localparam logic [15:0] POS_VHL    = 16'd14;
    localparam logic [15:0] POS_LEN_HI = 16'd16;
    localparam logic [15:0] POS_LEN_LO = 16'd17;
    localparam logic [15:0] POS_PROTO  = 16'd23;
    localparam logic [15:0] IP_START   = 16'd30;
    localparam logic [15:0] MIN_FRAME  = 16'd34;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    localparam logic [7:0]  VHL_EXPECTED = 8'h45;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [15:0] SUM_GOOD     = 16'hFFFF;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ADDR      = 3'd1;
    localparam logic [2:0] ST_VERSION   = 3'd2;
    localparam logic [2:0] ST_NOT_UDP   = 3'd3;
    localparam logic [2:0] ST_LENGTH    = 3'd4;
    localparam logic [2:0] ST_CHECKSUM  = 3'd5;
    localparam logic [2:0] ST_TRUNCATED = 3'd6;

    // register indexes (paddr[3])
    localparam logic REG_LOCAL_MAC = 1'b0;
    localparam logic REG_LOCAL_IP  = 1'b1;

    typedef struct packed {
        logic [47:0] local_mac;
        logic [31:0] local_ip;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic [15:0] ip_total_length;
    } result_t;

    // 16-bit ones' complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

endpackage
`default_nettype wire

// ----- hdl/ipv4_udp_frame_validator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A frame's last byte passes from the input register through the parser into the result register on m_*.
// Throughput: one byte per clock, set by the single registered pass through the parser.
// Only a last byte can stall, when the previous status is still waiting on m_tready.
// Reset: aresetn synchronous active low; clears frame state, both valid flags and
// the MAC/IP registers.
// ----------------------------------------------------------------------------
// ipv4_udp_frame_validator
// Streams an Ethernet II frame byte by byte, checks the IPv4/UDP header and
// reports one status per frame.
// ----------------------------------------------------------------------------
module ipv4_udp_frame_validator (
    input  wire         aclk,
    input  wire         aresetn,
    // byte stream in
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire         s_tlast,   // frame_end
    // status out
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // [2:0] status, [18:3] ip_total_length, [23:19] zero
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import ipv4v_pkg::*;

    cfg_t    cfg;
    result_t result;

    // input register
    logic  in_valid_reg;
    item_t in_item_reg;

    // result register
    logic        m_valid_reg;
    logic [2:0]  m_status_reg;
    logic [15:0] m_len_reg;

    logic stall;
    logic step;

    ipv4v_csr u_csr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // A last byte needs the result register free (or draining this cycle).
    assign stall    = in_valid_reg && in_item_reg.frame_end && m_valid_reg && !m_tready;
    assign step     = in_valid_reg && !stall;
    assign s_tready = !in_valid_reg || !stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.data_byte <= s_tdata;
            in_item_reg.frame_end <= s_tlast;
        end
    end

    ipv4v_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid) begin
            m_status_reg <= result.status;
            m_len_reg    <= result.ip_total_length;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_len_reg, m_status_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // a processed last byte always lands in the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_item_reg.frame_end && !stall) |=> m_tvalid)
        else $error("end-of-frame transfer produced no status");

    // a waiting status is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending status lost or changed");

    // truncated frames carry a zero length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] == ST_TRUNCATED) |-> (m_tdata[18:3] == 16'd0))
        else $error("truncated status with nonzero length");

    // non-final bytes never stall the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_item_reg.frame_end) |-> s_tready)
        else $error("stall on a non-final byte");

endmodule
`default_nettype wire

// ----- hdl/ipv4v_csr.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4v_csr
// APB-style register file holding the station MAC and IP addresses.
// ----------------------------------------------------------------------------
module ipv4v_csr (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [3:0]        paddr,
    input  wire  [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output ipv4v_pkg::cfg_t   cfg
);
    import ipv4v_pkg::*;

    logic [47:0] local_mac_reg;
    logic [31:0] local_ip_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_mac_reg <= '0;
            local_ip_reg  <= '0;
        end else if (wr_en) begin
            case (paddr[3])
                REG_LOCAL_MAC: local_mac_reg <= pwdata[47:0];
                REG_LOCAL_IP:  local_ip_reg  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            REG_LOCAL_MAC: prdata = {16'd0, local_mac_reg};
            REG_LOCAL_IP:  prdata = {32'd0, local_ip_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.local_mac = local_mac_reg;
    assign cfg.local_ip  = local_ip_reg;

endmodule
`default_nettype wire

// ----- hdl/ipv4v_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4v_parser
// Per-byte frame state: address/version/protocol checks, header checksum,
// length capture and end-of-frame status.
// ----------------------------------------------------------------------------
module ipv4v_parser (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 step,
    input  ipv4v_pkg::item_t    item,
    input  ipv4v_pkg::cfg_t     cfg,
    output ipv4v_pkg::result_t  result
);
    import ipv4v_pkg::*;

    logic [15:0] byte_count_reg,      byte_count_next;
    logic [15:0] checksum_acc_reg,    checksum_acc_next;
    logic [7:0]  pending_high_reg,    pending_high_next;
    logic        addr_mismatch_reg,   addr_mismatch_next;
    logic        version_bad_reg,     version_bad_next;
    logic        protocol_bad_reg,    protocol_bad_next;
    logic [15:0] captured_len_reg,    captured_len_next;

    logic [15:0] pos;
    logic [7:0]  b;
    logic [7:0]  mac_want;
    logic [7:0]  ip_want;

    assign pos = byte_count_reg;
    assign b   = item.data_byte;

    always_comb begin
        case (pos[2:0])
            3'd0:    mac_want = cfg.local_mac[47:40];
            3'd1:    mac_want = cfg.local_mac[39:32];
            3'd2:    mac_want = cfg.local_mac[31:24];
            3'd3:    mac_want = cfg.local_mac[23:16];
            3'd4:    mac_want = cfg.local_mac[15:8];
            default: mac_want = cfg.local_mac[7:0];
        endcase
    end

    // positions 30..33 have low bits 2,3,0,1
    always_comb begin
        case (pos[1:0])
            2'd2:    ip_want = cfg.local_ip[31:24];
            2'd3:    ip_want = cfg.local_ip[23:16];
            2'd0:    ip_want = cfg.local_ip[15:8];
            default: ip_want = cfg.local_ip[7:0];
        endcase
    end

    always_comb begin
        byte_count_next    = byte_count_reg;
        checksum_acc_next  = checksum_acc_reg;
        pending_high_next  = pending_high_reg;
        addr_mismatch_next = addr_mismatch_reg;
        version_bad_next   = version_bad_reg;
        protocol_bad_next  = protocol_bad_reg;
        captured_len_next  = captured_len_reg;
        result.valid           = 1'b0;
        result.status          = ST_OK;
        result.ip_total_length = '0;

        if (step) begin
            // past saturation bytes only extend the frame
            if (byte_count_reg != COUNT_MAX) begin
                if (pos < MAC_END && b != mac_want) begin
                    addr_mismatch_next = 1'b1;
                end
                if (pos >= HDR_START && pos < MIN_FRAME) begin
                    if (!pos[0]) begin
                        pending_high_next = b;
                    end else begin
                        checksum_acc_next = ones_add(checksum_acc_reg, {pending_high_reg, b});
                    end
                end
                if (pos == POS_VHL && b != VHL_EXPECTED) begin
                    version_bad_next = 1'b1;
                end
                if (pos == POS_LEN_HI) begin
                    captured_len_next = {b, 8'd0};
                end
                if (pos == POS_LEN_LO) begin
                    captured_len_next = {captured_len_reg[15:8], b};
                end
                if (pos == POS_PROTO && b != PROTO_UDP) begin
                    protocol_bad_next = 1'b1;
                end
                if (pos >= IP_START && pos < MIN_FRAME && b != ip_want) begin
                    addr_mismatch_next = 1'b1;
                end
                byte_count_next = byte_count_reg + 16'd1;
            end

            if (item.frame_end) begin
                result.valid           = 1'b1;
                result.ip_total_length = captured_len_next;
                if (byte_count_next < MIN_FRAME) begin
                    result.status          = ST_TRUNCATED;
                    result.ip_total_length = '0;
                end else if (addr_mismatch_next) begin
                    result.status = ST_ADDR;
                end else if (version_bad_next) begin
                    result.status = ST_VERSION;
                end else if (protocol_bad_next) begin
                    result.status = ST_NOT_UDP;
                end else if (captured_len_next > byte_count_next) begin
                    result.status = ST_LENGTH;
                end else if (checksum_acc_next != SUM_GOOD && checksum_acc_next != 16'd0) begin
                    result.status = ST_CHECKSUM;
                end else begin
                    result.status = ST_OK;
                end
                // clear per-frame state
                byte_count_next    = '0;
                checksum_acc_next  = '0;
                pending_high_next  = '0;
                addr_mismatch_next = 1'b0;
                version_bad_next   = 1'b0;
                protocol_bad_next  = 1'b0;
                captured_len_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg    <= '0;
            checksum_acc_reg  <= '0;
            pending_high_reg  <= '0;
            addr_mismatch_reg <= 1'b0;
            version_bad_reg   <= 1'b0;
            protocol_bad_reg  <= 1'b0;
            captured_len_reg  <= '0;
        end else begin
            byte_count_reg    <= byte_count_next;
            checksum_acc_reg  <= checksum_acc_next;
            pending_high_reg  <= pending_high_next;
            addr_mismatch_reg <= addr_mismatch_next;
            version_bad_reg   <= version_bad_next;
            protocol_bad_reg  <= protocol_bad_next;
            captured_len_reg  <= captured_len_next;
        end
    end

endmodule
`default_nettype wire

// ----- tb/tb_ipv4_udp_frame_validator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_udp_frame_validator
// Self-checking bench for the IPv4/UDP frame validator. Frames are built
// byte by byte with a known header and optional planted faults, streamed
// under several stall patterns, and each status transfer is checked against
// its directed row or a behavioral header check model kept in the bench.
// ----------------------------------------------------------------------------
module tb_ipv4_udp_frame_validator;
    import ipv4v_pkg::*;

    localparam int WATCHDOG_LIMIT   = 5000;  // cycles with no transfer at all
    localparam int FRAMES_PER_PHASE = 2;
    localparam int HOLD_CYCLES      = 400;   // long m_tready hold-off
    localparam int DRILL_ROWS       = 13;

    // faults planted into a built frame
    localparam logic [7:0] F_NONE  = 8'h00;
    localparam logic [7:0] F_MAC   = 8'h01;  // flip a bit of the destination MAC
    localparam logic [7:0] F_IP    = 8'h02;  // flip a bit of the destination IP
    localparam logic [7:0] F_VER   = 8'h04;  // version/IHL other than 0x45
    localparam logic [7:0] F_PROTO = 8'h08;  // protocol other than UDP
    localparam logic [7:0] F_LONG  = 8'h10;  // total length beyond the frame
    localparam logic [7:0] F_SUM   = 8'h20;  // flip a bit of an unchecked header byte
    localparam logic [7:0] F_ZERO  = 8'h40;  // whole IPv4 header zero
    localparam logic [7:0] F_NOISE = 8'h80;  // first 34 bytes random

    typedef struct packed {
        logic        from_table;  // expectation typed in the directed table
        logic [2:0]  st;
        logic [15:0] tl;
    } status_note_t;

    typedef struct packed {
        logic [16:0] len;
        logic [15:0] tot;
        logic [7:0]  faults;
        logic        typed;
        logic [2:0]  st;
        logic [15:0] tl;
    } drill_row_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [23:0] m_tdata;  // [2:0] status, [18:3] ip_total_length
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [63:0] pwdata   = '0;
    wire  [63:0] prdata;
    wire         pready;

    ipv4_udp_frame_validator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    int err_cnt      = 0;
    int quiet_cycles = 0;
    int src_idle_pct = 0;   // chance per transfer of a sender gap
    int sink_stall_pct = 0; // chance per cycle of m_tready low
    bit hold_req     = 1'b0;
    int hold_left    = 0;

    status_note_t frame_note_q[$];       // one per frame, pushed before it is sent
    status_note_t status_expected_q[$];  // statuses owed by the block, oldest first
    logic [7:0]   frame_bytes[$];

    // station addresses as the block should hold them
    logic [47:0] cfg_mac = '0;
    logic [31:0] cfg_ip  = '0;

    // per-frame state of the header check model
    logic [15:0] hc_count     = '0;
    logic [15:0] hc_sum       = '0;
    logic [7:0]  hc_hi        = '0;
    logic        hc_addr_bad  = 1'b0;
    logic        hc_ver_bad   = 1'b0;
    logic        hc_proto_bad = 1'b0;
    logic [15:0] hc_len       = '0;

    // Directed frames. Rows with typed=1 carry the status read straight off
    // the header; the noise row goes through the model.
    drill_row_t drill_rows [DRILL_ROWS] = '{
        // reset config: MAC and IP both zero
        '{17'd34,    16'd34,     F_NONE,  1'b1, ST_OK,        16'd34},     // length == count
        '{17'd34,    16'd35,     F_LONG,  1'b1, ST_LENGTH,    16'd35},     // one past count
        '{17'd1,     16'd0,      F_NONE,  1'b1, ST_TRUNCATED, 16'd0},      // last on byte 0
        '{17'd33,    16'd20,     F_NONE,  1'b1, ST_TRUNCATED, 16'd0},      // one byte short
        '{17'd20,    16'd0,      F_MAC,   1'b1, ST_TRUNCATED, 16'd0},      // truncation wins
        '{17'd34,    16'd26,     F_IP,    1'b1, ST_ADDR,      16'd26},
        '{17'd34,    16'd26,     F_SUM,   1'b1, ST_CHECKSUM,  16'd26},
        // priority ladder, all with total length 0xFFFF > 34
        '{17'd34,    16'hFFFF,   F_MAC | F_IP | F_VER | F_PROTO | F_SUM,
                                          1'b1, ST_ADDR,      16'hFFFF},
        '{17'd34,    16'hFFFF,   F_VER | F_PROTO | F_SUM,
                                          1'b1, ST_VERSION,   16'hFFFF},
        '{17'd34,    16'hFFFF,   F_PROTO | F_SUM,
                                          1'b1, ST_NOT_UDP,   16'hFFFF},
        '{17'd34,    16'hFFFF,   F_SUM,   1'b1, ST_LENGTH,    16'hFFFF},
        // all-zero header: its zero sum passes the checksum test, the version check reports it
        '{17'd34,    16'd0,      F_ZERO,  1'b1, ST_VERSION,   16'd0},
        '{17'd34,    16'd0,      F_NOISE, 1'b0, ST_OK,        16'd0}
    };

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= 40)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Header check model: one byte in, a status out on the last byte
    // ------------------------------------------------------------------------
    task automatic check_header_byte(input logic [7:0] b, input logic last,
                                     output logic has_status, output logic [2:0] st,
                                     output logic [15:0] tl);
        int          pos;
        logic [16:0] acc;
        pos        = int'(hc_count);
        has_status = 1'b0;
        st         = ST_OK;
        tl         = '0;
        // past 65535 bytes nothing more is examined
        if (hc_count != COUNT_MAX) begin
            if (pos < 6) begin
                if (b != cfg_mac[8*(5-pos) +: 8])
                    hc_addr_bad = 1'b1;
            end
            if (pos >= 14 && pos < 34) begin
                if (pos % 2 == 0) begin
                    hc_hi = b;
                end else begin
                    acc    = hc_sum + {hc_hi, b};
                    hc_sum = acc[15:0] + acc[16];  // end-around carry
                end
            end
            if (pos == 14 && b != VHL_EXPECTED)
                hc_ver_bad = 1'b1;
            if (pos == 16)
                hc_len = {b, 8'h00};
            if (pos == 17)
                hc_len[7:0] = b;
            if (pos == 23 && b != PROTO_UDP)
                hc_proto_bad = 1'b1;
            if (pos >= 30 && pos < 34) begin
                if (b != cfg_ip[8*(33-pos) +: 8])
                    hc_addr_bad = 1'b1;
            end
            hc_count = hc_count + 16'd1;
        end
        if (last) begin
            has_status = 1'b1;
            tl         = hc_len;
            if (hc_count < MIN_FRAME) begin
                st = ST_TRUNCATED;
                tl = '0;
            end else if (hc_addr_bad) begin
                st = ST_ADDR;
            end else if (hc_ver_bad) begin
                st = ST_VERSION;
            end else if (hc_proto_bad) begin
                st = ST_NOT_UDP;
            end else if (hc_len > hc_count) begin
                st = ST_LENGTH;
            end else if (hc_sum != SUM_GOOD && hc_sum != 16'h0000) begin
                st = ST_CHECKSUM;
            end
            hc_count     = '0;
            hc_sum       = '0;
            hc_hi        = '0;
            hc_addr_bad  = 1'b0;
            hc_ver_bad   = 1'b0;
            hc_proto_bad = 1'b0;
            hc_len       = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: status check first, then the byte transfer of the same edge.
    // A status can never belong to a byte taken at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        logic         has_status;
        logic [2:0]   st;
        logic [15:0]  tl;
        status_note_t note;
        status_note_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (status_expected_q.size() == 0) begin
                    report_mismatch($sformatf("status %0d with none outstanding",
                                              m_tdata[2:0]));
                end else begin
                    want = status_expected_q.pop_front();
                    if (m_tdata[2:0] !== want.st)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  m_tdata[2:0], want.st));
                    if (m_tdata[18:3] !== want.tl)
                        report_mismatch($sformatf("ip_total_length got %h want %h",
                                                  m_tdata[18:3], want.tl));
                end
            end
            if (s_tvalid && s_tready) begin
                check_header_byte(s_tdata, s_tlast, has_status, st, tl);
                if (has_status) begin
                    note = frame_note_q.pop_front();
                    if (note.from_table)
                        status_expected_q.push_back(note);
                    else
                        status_expected_q.push_back('{1'b0, st, tl});
                end
            end
        end
    end

    // Sink: random stalls, or a counted hold-off when asked for
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: any transfer on any port restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_ipv4_udp_frame_validator: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // APB write of one register, then read back
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic idx, input logic [63:0] value);
        logic [63:0] held;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // registers keep only their own width
        if (idx == REG_LOCAL_MAC) begin
            cfg_mac = value[47:0];
            held    = {16'h0000, value[47:0]};
        end else begin
            cfg_ip = value[31:0];
            held   = {32'h0, value[31:0]};
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== held)
            report_mismatch($sformatf("readback reg %0d got %h want %h", idx, prdata, held));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Builds an Ethernet II + IPv4 frame addressed to the station, with a
    // valid header checksum, then plants the requested faults.
    task automatic send_frame(input int len, input logic [15:0] tot, input logic [7:0] faults);
        logic [7:0]  hdr [0:33];
        logic [15:0] sum;
        logic [16:0] acc;
        int          idx;
        for (int i = 0; i < 34; i++)
            hdr[i] = 8'($urandom);
        for (int i = 0; i < 6; i++)
            hdr[i] = cfg_mac[8*(5-i) +: 8];
        hdr[12] = 8'h08;  // ethertype IPv4
        hdr[13] = 8'h00;
        hdr[14] = VHL_EXPECTED;
        hdr[16] = tot[15:8];
        hdr[17] = tot[7:0];
        hdr[23] = PROTO_UDP;
        for (int i = 0; i < 4; i++)
            hdr[30+i] = cfg_ip[8*(3-i) +: 8];
        if (faults & F_MAC) begin
            idx = $urandom_range(0, 5);
            hdr[idx] ^= 8'(1 << $urandom_range(0, 7));
        end
        if (faults & F_IP) begin
            idx = $urandom_range(30, 33);
            hdr[idx] ^= 8'(1 << $urandom_range(0, 7));
        end
        if (faults & F_VER)
            hdr[14] = VHL_EXPECTED ^ 8'($urandom_range(1, 255));
        if (faults & F_PROTO)
            hdr[23] = PROTO_UDP ^ 8'($urandom_range(1, 255));
        hdr[24] = 8'h00;
        hdr[25] = 8'h00;
        sum = '0;
        for (int i = 14; i < 34; i += 2) begin
            acc = sum + {hdr[i], hdr[i+1]};
            sum = acc[15:0] + acc[16];
        end
        hdr[24] = ~sum[15:8];
        hdr[25] = ~sum[7:0];
        // one flipped bit can never turn 0xFFFF into 0x0000, so the sum breaks
        if (faults & F_SUM) begin
            idx = $urandom_range(0, 10);
            idx = (idx < 5) ? 18 + idx : 19 + idx;
            hdr[idx] ^= 8'(1 << $urandom_range(0, 7));
        end
        if (faults & F_ZERO) begin
            for (int i = 14; i < 34; i++)
                hdr[i] = 8'h00;
        end
        if (faults & F_NOISE) begin
            for (int i = 0; i < 34; i++)
                hdr[i] = 8'($urandom);
        end
        frame_bytes.delete();
        for (int i = 0; i < len; i++)
            frame_bytes.push_back((i < 34) ? hdr[i] : 8'($urandom));
        for (int i = 0; i < len; i++)
            send_byte(frame_bytes[i], i == len - 1);
    endtask

    // Half short frames, the rest full-size; some faulted or noise.
    task automatic random_frame(input int max_len);
        int          len;
        int          pick;
        logic [7:0]  faults;
        logic [15:0] tot;
        pick = $urandom_range(99);
        if (pick < 50)
            len = $urandom_range(1, 33);
        else
            len = $urandom_range(34, max_len);
        faults = F_NONE;
        if ($urandom_range(99) < 10) begin
            faults = F_NOISE;
        end else if ($urandom_range(99) < 40) begin
            if ($urandom_range(99) < 30) faults |= F_MAC;
            if ($urandom_range(99) < 30) faults |= F_IP;
            if ($urandom_range(99) < 30) faults |= F_VER;
            if ($urandom_range(99) < 30) faults |= F_PROTO;
            if ($urandom_range(99) < 30) faults |= F_LONG;
            if ($urandom_range(99) < 30) faults |= F_SUM;
        end
        if (len < 34)
            tot = 16'($urandom);
        else if (faults & F_LONG)
            tot = 16'($urandom_range(len + 1, 65535));
        else
            tot = 16'($urandom_range(0, len));
        frame_note_q.push_back('{1'b0, ST_OK, 16'h0});
        send_frame(len, tot, faults);
    endtask

    // Wait until every owed status has come back, plus the pipeline depth
    task automatic settle();
        s_tvalid <= 1'b0;
        while (status_expected_q.size() != 0 || frame_note_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [47:0] mac, input logic [31:0] ip);
        logic [63:0] junk;
        settle();
        junk = {$urandom, $urandom};
        // upper pwdata bits carry junk: the registers must mask it off
        write_reg(REG_LOCAL_MAC, {junk[63:48], mac});
        write_reg(REG_LOCAL_IP, {junk[31:0], ip});
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (int k = 0; k < FRAMES_PER_PHASE; k++)
            random_frame(40);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [63:0] rnd_a;
        logic [63:0] rnd_b;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames against the reset addresses, no idling
        for (int r = 0; r < DRILL_ROWS; r++) begin
            frame_note_q.push_back('{drill_rows[r].typed, drill_rows[r].st,
                                     drill_rows[r].tl});
            send_frame(int'(drill_rows[r].len), drill_rows[r].tot, drill_rows[r].faults);
        end

        rnd_a = {$urandom, $urandom};
        rnd_b = {$urandom, $urandom};
        run_phase(0, 0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(68, 0, rnd_a[47:0], rnd_b[31:0]);
        run_phase(0, 68, 48'h0, rnd_a[63:32]);
        run_phase(17, 17, rnd_b[63:16], 32'h0);

        // back-pressure: sink holds off while short frames keep coming, so
        // the status slot fills and the block must stall a last byte
        settle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req = 1'b1;
        for (int k = 0; k < 6; k++) begin
            frame_note_q.push_back('{1'b0, ST_OK, 16'h0});
            send_frame($urandom_range(1, 3), 16'h0, F_NONE);
        end

        settle();
        repeat (20) @(posedge aclk);
        if (err_cnt == 0)
            $display("tb_ipv4_udp_frame_validator: done, clean");
        else
            $display("tb_ipv4_udp_frame_validator: done, errors");
        $finish;
    end

endmodule
